// ----- hdl/uer_pkg.sv -----
package uer_pkg;

  localparam int CNT_W  = 17;
  localparam int DUR_W  = 16;
  localparam int DIST_W = 11;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_PULSE = 3'd2;
  localparam logic [2:0] PH_RISE  = 3'd3;
  localparam logic [2:0] PH_HIGH  = 3'd4;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SETUP   = 2'd1;
  localparam logic [1:0] REG_PULSE   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd6500;
  localparam logic [7:0]  SETUP_RST   = 8'd5;
  localparam logic [7:0]  PULSE_RST   = 8'd10;

  // floor(d*10/582) = floor(d*5/291) = (d * 5 * ceil(2^28/291)) >> 28, exact for d < 2^16
  localparam int           DIST_SHIFT = 28;
  localparam logic [22:0]  DIST_MUL   = 23'd4612295;
  localparam int           PROD_W     = DUR_W + 23;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  trigger_setup_ticks;
    logic [7:0]  trigger_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic sensor;
    logic echo_left;
    logic echo_right;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic              timed_out;
    logic              done_res;
    logic              busy_res;
    logic              trigger_right;
    logic              trigger_left;
  } out_word_t;

endpackage

// ----- hdl/uer_cfg_regs.sv -----
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_TIMEOUT: cfg_nxt.timeout_limit       = pwdata[15:0];
        REG_SETUP:   cfg_nxt.trigger_setup_ticks = pwdata[7:0];
        REG_PULSE:   cfg_nxt.trigger_pulse_ticks = pwdata[7:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit       <= TIMEOUT_RST;
      cfg_r.trigger_setup_ticks <= SETUP_RST;
      cfg_r.trigger_pulse_ticks <= PULSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT: prdata = {16'd0, cfg_r.timeout_limit};
      REG_SETUP:   prdata = {24'd0, cfg_r.trigger_setup_ticks};
      REG_PULSE:   prdata = {24'd0, cfg_r.trigger_pulse_ticks};
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/uer_in_reg.sv -----
module uer_in_reg
  import uer_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     s1_valid,
  output in_word_t s1_word,
  input  logic     s1_take
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  // Refill in the same cycle the held word moves on
  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

// ----- hdl/uer_ctrl.sv -----
module uer_ctrl
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      s1_valid,
  input  in_word_t  s1_word,
  output logic      s1_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] dur_r, dur_nxt;
  logic             sensor_r, sensor_nxt;
  logic             valid_r;
  out_word_t        word_r, word_nxt;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  dur_inc;
  logic [PROD_W-1:0] prod;
  logic              echo;
  logic              trig;
  logic              done;
  logic              tmo;
  logic [DIST_W-1:0] dist_val;

  assign s1_take = s1_valid && (!valid_r || out_ready);

  // Zero limit means the full 16-bit range
  assign limit = (cfg.timeout_limit == 16'd0) ? {1'b1, 16'd0} : {1'b0, cfg.timeout_limit};
  assign cnt_inc = count_r + CNT_W'(1);
  assign prod = dur_r[DUR_W-1:0] * DIST_MUL;
  assign echo = sensor_r ? s1_word.echo_right : s1_word.echo_left;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    dur_nxt    = dur_r;
    sensor_nxt = sensor_r;
    trig       = 1'b0;
    done       = 1'b0;
    tmo        = 1'b0;
    dist_val   = '0;
    // A rising sample counts as the first high sample
    dur_inc    = ((phase_r == PH_RISE) ? '0 : dur_r) + CNT_W'(1);
    if (s1_word.op == OP_START) begin
      if (phase_r == PH_IDLE) begin
        sensor_nxt = s1_word.sensor;
        count_nxt  = '0;
        dur_nxt    = '0;
        phase_nxt  = (cfg.trigger_setup_ticks == 8'd0) ? PH_PULSE : PH_SETUP;
      end
    end else begin
      case (phase_r)
        PH_SETUP: begin
          count_nxt = cnt_inc;
          if (cnt_inc >= {9'd0, cfg.trigger_setup_ticks}) begin
            phase_nxt = PH_PULSE;
            count_nxt = '0;
          end
        end
        PH_PULSE: begin
          trig      = 1'b1;
          count_nxt = cnt_inc;
          if (cnt_inc >= {9'd0, cfg.trigger_pulse_ticks}) begin
            phase_nxt = PH_RISE;
            count_nxt = '0;
          end
        end
        PH_RISE, PH_HIGH: begin
          if (phase_r == PH_RISE && !echo) begin
            count_nxt = cnt_inc;
            if (cnt_inc >= limit) begin
              done = 1'b1;
              tmo  = 1'b1;
            end
          end else if (echo) begin
            phase_nxt = PH_HIGH;
            count_nxt = '0;
            dur_nxt   = dur_inc;
            if (dur_inc >= limit) begin
              done = 1'b1;
              tmo  = 1'b1;
            end
          end else begin
            done     = 1'b1;
            dist_val = prod[PROD_W-1:DIST_SHIFT];
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (done) begin
        phase_nxt = PH_IDLE;
        count_nxt = '0;
        dur_nxt   = {1'b0, dur_nxt[DUR_W-1:0]};
      end
    end

    word_nxt.trigger_left  = trig && !sensor_nxt;
    word_nxt.trigger_right = trig && sensor_nxt;
    word_nxt.busy_res      = (phase_nxt != PH_IDLE);
    word_nxt.done_res      = done;
    word_nxt.timed_out     = tmo;
    word_nxt.distance_cm   = dist_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      dur_r    <= '0;
      sensor_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (s1_take) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        dur_r    <= dur_nxt;
        sensor_r <= sensor_nxt;
      end
      if (s1_take) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ----- hdl/ultrasonic_echo_ranger.sv -----
// Ranging controller for two ultrasonic echo sensors. Feed one word per
// microsecond tick (tuser 0) and a start word (tuser 1) to begin a
// measurement on the chosen sensor; every input word yields exactly one
// result word carrying the trigger levels, busy, done, timeout and distance
// in cm. The block takes one word per clock while out_tready is high, passing
// it through an input register, then the phase counter update and the distance
// scaling (one constant multiplier) into the result register. Registers:
// 0x0 timeout_limit, 0x4 trigger_setup_ticks, 0x8 trigger_pulse_ticks;
// write them only while no measurement is running.
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] sensor, [1] echo_left, [2] echo_right
  input  logic              in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] trigger_left, [1] trigger_right, [2] busy_res, [3] done_res,
  // [4] timed_out, [15:5] distance_cm
  output logic [15:0]       out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t      cfg;
  in_word_t  in_word;
  in_word_t  s1_word;
  logic      s1_valid;
  logic      s1_take;
  out_word_t out_word;

  assign cfg_pready = 1'b1;

  assign in_word.op         = in_tuser;
  assign in_word.sensor     = in_tdata[0];
  assign in_word.echo_left  = in_tdata[1];
  assign in_word.echo_right = in_tdata[2];

  uer_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  uer_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s1_take  (s1_take)
  );

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word),
    .s1_take   (s1_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = out_word;

endmodule

// ----- hdl/uer_checker.sv -----
module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2] && !out_tdata[0] && !out_tdata[1])
    else $error("done word shows busy or trigger");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4] || out_tdata[15:5] != 11'd0)
      |-> out_tdata[3] && !(out_tdata[4] && out_tdata[15:5] != 11'd0))
    else $error("timeout or distance without done");

  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1])
      |-> out_tdata[2] && !(out_tdata[0] && out_tdata[1]))
    else $error("trigger outside a measurement");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
